// ===== rtl/core/door_mon_pkg.sv =====
// Shared types and constants for the door open monitor.
package door_mon_pkg;

    localparam int TIMER_BITS = 24;
    localparam int LIMIT_BITS = 24;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 24;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [SAMPLE_BITS-1:0] sample_cnt_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OPEN_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_INTERVAL = 2'd2;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_INTERVAL_RESET = 16'd50;

    // Input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Reported door state codes
    localparam logic [1:0] STATE_CLOSED = 2'd0;
    localparam logic [1:0] STATE_OPEN = 2'd1;
    localparam logic [1:0] STATE_TOO_LONG = 2'd2;

    typedef enum logic [2:0] {
        MODE_CLOSED = 3'b001,
        MODE_OPEN = 3'b010,
        MODE_TOO_LONG = 3'b100
    } mode_t;

    typedef struct packed {
        logic cmd;
        logic door_pin;
    } in_item_t;

    typedef struct packed {
        logic [1:0] door_state;
        logic event_opened;
        logic event_too_long;
        logic event_closed;
        logic led_on;
        logic beep_request;
    } out_item_t;

endpackage

// ===== rtl/core/door_open_monitor_core.sv =====
// Door open monitor: door state machine, tick countdowns and result buffering.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_data  (cmd, door_pin)
//  out     | output    | out_valid / out_ready | out_data (state, events, led, beep)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each item is handled in the cycle of its transfer; its result is registered in the
// output register, or in the skid register while the output waits, one item per cycle while results are taken.
// A skid register holds one more result, so a new item is taken while the
// output waits; in_ready drops only when both result slots are full.
// cfg_ready is always high. Reset: all state cleared, sample interval 50.
module door_open_monitor_core (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  door_mon_pkg::in_item_t                     in_data,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output door_mon_pkg::out_item_t                    out_data,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [door_mon_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [door_mon_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    logic [door_mon_pkg::LIMIT_BITS-1:0] open_limit_reg;
    logic                                invert_reg;
    door_mon_pkg::sample_cnt_t           sample_interval_reg;

    door_mon_pkg::mode_t                 mode_reg, mode_next;
    door_mon_pkg::timer_t                open_cnt_reg, open_cnt_next;
    door_mon_pkg::sample_cnt_t           sample_cnt_reg, sample_cnt_next;
    logic                                cached_open_reg, cached_open_next;
    logic                                led_reg, led_next;

    door_mon_pkg::out_item_t             out_reg, skid_reg, result;
    logic                                out_valid_reg, skid_valid_reg;

    logic in_fire;
    logic out_fire;
    logic alarm_on;
    logic sample_now;
    logic door_open;

    assign in_ready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    assign alarm_on   = (open_limit_reg != '0);
    assign sample_now = (sample_cnt_reg == '0);
    assign door_open  = sample_now ? (in_data.door_pin ^ invert_reg) : cached_open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_limit_reg      <= '0;
            invert_reg          <= 1'b0;
            sample_interval_reg <= door_mon_pkg::SAMPLE_INTERVAL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                door_mon_pkg::CFG_OPEN_LIMIT:
                    open_limit_reg <= cfg_data[door_mon_pkg::LIMIT_BITS-1:0];
                door_mon_pkg::CFG_INVERT:
                    invert_reg <= cfg_data[0];
                door_mon_pkg::CFG_SAMPLE_INTERVAL:
                    sample_interval_reg <= cfg_data[door_mon_pkg::SAMPLE_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        mode_next        = mode_reg;
        open_cnt_next    = open_cnt_reg;
        sample_cnt_next  = sample_cnt_reg;
        cached_open_next = cached_open_reg;
        led_next         = led_reg;
        result           = '0;

        if (in_data.cmd == door_mon_pkg::CMD_TICK)
        begin
            if (open_cnt_reg != '0)
                open_cnt_next = open_cnt_reg - 1'b1;
            if (sample_cnt_reg != '0)
                sample_cnt_next = sample_cnt_reg - 1'b1;
        end
        else
        begin
            // every mode samples the contact on a step once the sample countdown has run out
            if (sample_now)
            begin
                sample_cnt_next  = sample_interval_reg;
                cached_open_next = door_open;
            end
            case (mode_reg)
                door_mon_pkg::MODE_OPEN:
                begin
                    led_next = 1'b1;
                    if (open_cnt_reg == '0 && alarm_on)
                    begin
                        mode_next             = door_mon_pkg::MODE_TOO_LONG;
                        result.event_too_long = 1'b1;
                    end
                    if (!door_open)
                    begin
                        mode_next           = door_mon_pkg::MODE_CLOSED;
                        result.event_closed = 1'b1;
                    end
                end
                door_mon_pkg::MODE_TOO_LONG:
                begin
                    result.beep_request = 1'b1;
                    if (!door_open)
                    begin
                        mode_next           = door_mon_pkg::MODE_CLOSED;
                        result.event_closed = 1'b1;
                    end
                end
                default:
                begin
                    if (door_open)
                    begin
                        mode_next           = door_mon_pkg::MODE_OPEN;
                        result.event_opened = 1'b1;
                        if (alarm_on)
                            open_cnt_next = door_mon_pkg::timer_t'(open_limit_reg);
                    end
                    else
                    begin
                        mode_next = door_mon_pkg::MODE_CLOSED;
                        led_next  = 1'b0;
                    end
                end
            endcase
        end

        case (mode_next)
            door_mon_pkg::MODE_OPEN:     result.door_state = door_mon_pkg::STATE_OPEN;
            door_mon_pkg::MODE_TOO_LONG: result.door_state = door_mon_pkg::STATE_TOO_LONG;
            default:                     result.door_state = door_mon_pkg::STATE_CLOSED;
        endcase
        result.led_on = led_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= door_mon_pkg::MODE_CLOSED;
            open_cnt_reg    <= '0;
            sample_cnt_reg  <= '0;
            cached_open_reg <= 1'b0;
            led_reg         <= 1'b0;
        end
        else if (in_fire)
        begin
            mode_reg        <= mode_next;
            open_cnt_reg    <= open_cnt_next;
            sample_cnt_reg  <= sample_cnt_next;
            cached_open_reg <= cached_open_next;
            led_reg         <= led_next;
        end
    end

    // Output register plus one skid entry; results leave in transfer order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (!out_valid_reg)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire && skid_valid_reg)
            out_reg <= skid_reg;
        if (in_fire)
        begin
            if (!out_valid_reg || out_ready)
                out_reg <= result;
            else
                skid_reg <= result;
        end
    end

endmodule

// ===== rtl/core/door_mon_checker.sv =====
// Port-level checker for the door open monitor, bound to the top level.
module door_mon_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input door_mon_pkg::out_item_t  out_data
);

    // a waiting result holds until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_opened |->
            out_data.door_state == door_mon_pkg::STATE_OPEN)
        else $error("opened event without open state");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_closed |->
            out_data.door_state == door_mon_pkg::STATE_CLOSED)
        else $error("closed event without closed state");

    // beep only comes from the too-long mode, which cannot open again
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.beep_request |->
            !out_data.event_opened && !out_data.event_too_long)
        else $error("beep together with opened or too-long event");

endmodule

bind door_open_monitor_core door_mon_checker u_door_mon_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/door_open_monitor_core_tb.sv =====
// Self-checking testbench for the door open monitor core.
module door_open_monitor_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // index outside the register list; writes to it must change nothing
    localparam logic [door_mon_pkg::CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 800;
    localparam int MAX_PRINTED = 30;

    // Tracks the door state machine and holds the results still owed by the block.
    class door_result_board;
        door_mon_pkg::timer_t      open_limit;
        logic                      invert;
        door_mon_pkg::sample_cnt_t sample_reload;

        logic [1:0]                door_mode;
        door_mon_pkg::timer_t      open_left;
        door_mon_pkg::sample_cnt_t sample_left;
        logic                      door_seen_open;
        logic                      led;

        door_mon_pkg::out_item_t   owed[$];
        int                        fails;

        function new();
            open_limit     = '0;
            invert         = 1'b0;
            sample_reload  = door_mon_pkg::SAMPLE_INTERVAL_RESET;
            door_mode      = door_mon_pkg::STATE_CLOSED;
            open_left      = '0;
            sample_left    = '0;
            door_seen_open = 1'b0;
            led            = 1'b0;
            fails          = 0;
        endfunction

        function void write_reg(logic [door_mon_pkg::CFG_INDEX_BITS-1:0] index,
                                logic [door_mon_pkg::CFG_DATA_BITS-1:0] data);
            case (index)
                door_mon_pkg::CFG_OPEN_LIMIT:
                    open_limit = data[door_mon_pkg::LIMIT_BITS-1:0];
                door_mon_pkg::CFG_INVERT:
                    invert = data[0];
                door_mon_pkg::CFG_SAMPLE_INTERVAL:
                    sample_reload = data[door_mon_pkg::SAMPLE_BITS-1:0];
                default: ;
            endcase
        endfunction

        // pin is only read once the sample countdown has run out
        function logic door_open_now(logic pin);
            if (sample_left == '0)
            begin
                sample_left = sample_reload;
                door_seen_open = pin ^ invert;
            end
            return door_seen_open;
        endfunction

        function void note_item(door_mon_pkg::in_item_t it);
            door_mon_pkg::out_item_t want;
            logic                    alarm_armed;
            want = '0;
            alarm_armed = (open_limit != '0);
            if (it.cmd == door_mon_pkg::CMD_TICK)
            begin
                if (open_left != '0)
                    open_left--;
                if (sample_left != '0)
                    sample_left--;
            end
            else
            begin
                case (door_mode)
                    door_mon_pkg::STATE_OPEN:
                    begin
                        led = 1'b1;
                        if (open_left == '0 && alarm_armed)
                        begin
                            door_mode = door_mon_pkg::STATE_TOO_LONG;
                            want.event_too_long = 1'b1;
                        end
                        if (!door_open_now(it.door_pin))
                        begin
                            door_mode = door_mon_pkg::STATE_CLOSED;
                            want.event_closed = 1'b1;
                        end
                    end
                    door_mon_pkg::STATE_TOO_LONG:
                    begin
                        want.beep_request = 1'b1;
                        if (!door_open_now(it.door_pin))
                        begin
                            door_mode = door_mon_pkg::STATE_CLOSED;
                            want.event_closed = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (door_open_now(it.door_pin))
                        begin
                            door_mode = door_mon_pkg::STATE_OPEN;
                            if (alarm_armed)
                                open_left = open_limit;
                            want.event_opened = 1'b1;
                        end
                        else
                        begin
                            door_mode = door_mon_pkg::STATE_CLOSED;
                            led = 1'b0;
                        end
                    end
                endcase
            end
            want.door_state = door_mode;
            want.led_on = led;
            owed.push_back(want);
        endfunction

        task report(string msg);
            if (fails < MAX_PRINTED)
                $display("mismatch at %0t: %s", $realtime, msg);
            fails++;
        endtask

        task check_result(door_mon_pkg::out_item_t got);
            door_mon_pkg::out_item_t want;
            if (owed.size() == 0)
            begin
                report($sformatf("result %h with no item outstanding", got));
                return;
            end
            want = owed.pop_front();
            if (got.door_state !== want.door_state)
                report($sformatf("door_state %0d, want %0d", got.door_state, want.door_state));
            if (got.event_opened !== want.event_opened)
                report($sformatf("event_opened %b, want %b",
                                 got.event_opened, want.event_opened));
            if (got.event_too_long !== want.event_too_long)
                report($sformatf("event_too_long %b, want %b",
                                 got.event_too_long, want.event_too_long));
            if (got.event_closed !== want.event_closed)
                report($sformatf("event_closed %b, want %b",
                                 got.event_closed, want.event_closed));
            if (got.led_on !== want.led_on)
                report($sformatf("led_on %b, want %b", got.led_on, want.led_on));
            if (got.beep_request !== want.beep_request)
                report($sformatf("beep_request %b, want %b",
                                 got.beep_request, want.beep_request));
        endtask
    endclass

    logic                                     clk = 1'b0;
    logic                                     rst_n = 1'b0;
    logic                                     in_valid = 1'b0;
    logic                                     in_ready;
    door_mon_pkg::in_item_t                   in_data = '0;
    logic                                     out_valid;
    logic                                     out_ready = 1'b0;
    door_mon_pkg::out_item_t                  out_data;
    logic                                     cfg_valid = 1'b0;
    logic                                     cfg_ready;
    logic [door_mon_pkg::CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [door_mon_pkg::CFG_DATA_BITS-1:0]   cfg_data = '0;

    door_result_board board = new();
    bit               gaps_on = 1'b1;
    logic             pin_level = 1'b0;
    int               quiet_cycles = 0;

    door_open_monitor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= gaps_on ? ($urandom_range(99) >= 19) : 1'b1;

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            board.check_result(out_data);

    // ends the run if nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Called and left at a falling edge; valid stays high for the next item.
    task automatic drive_item(logic cmd, logic pin);
        door_mon_pkg::in_item_t it;
        it.cmd = cmd;
        it.door_pin = pin;
        while (gaps_on && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_item(it);
        @(negedge clk);
    endtask

    // drop valid and let every owed result drain before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(logic [door_mon_pkg::CFG_INDEX_BITS-1:0] index,
                             logic [door_mon_pkg::CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_setting();
        logic [door_mon_pkg::CFG_DATA_BITS-1:0] noise;
        logic [door_mon_pkg::LIMIT_BITS-1:0]    limit;
        logic [door_mon_pkg::SAMPLE_BITS-1:0]   interval;
        noise = door_mon_pkg::CFG_DATA_BITS'($urandom);
        case ($urandom_range(9))
            0: limit = '0;
            1: limit = 24'd1;
            2: limit = 24'hFFFFFF;
            3: limit = door_mon_pkg::LIMIT_BITS'($urandom);
            default: limit = door_mon_pkg::LIMIT_BITS'($urandom_range(40, 2));
        endcase
        case ($urandom_range(7))
            0: interval = '0;
            1: interval = 16'd1;
            2: interval = 16'hFFFF;
            default: interval = door_mon_pkg::SAMPLE_BITS'($urandom_range(12, 2));
        endcase
        write_reg(door_mon_pkg::CFG_OPEN_LIMIT, limit);
        // upper data bits are don't-care for the narrow registers
        write_reg(door_mon_pkg::CFG_INVERT,
                  {noise[door_mon_pkg::CFG_DATA_BITS-1:1], 1'($urandom_range(1))});
        write_reg(door_mon_pkg::CFG_SAMPLE_INTERVAL,
                  {noise[door_mon_pkg::CFG_DATA_BITS-1:door_mon_pkg::SAMPLE_BITS], interval});
        if ($urandom_range(3) == 0)
            write_reg(CFG_UNMAPPED, door_mon_pkg::CFG_DATA_BITS'($urandom));
    endtask

    initial
    begin
        int sent;
        int phase;
        int run_len;
        sent = 0;
        phase = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: no alarm, interval 50
        drive_item(door_mon_pkg::CMD_STEP, 1'b1);
        drive_item(door_mon_pkg::CMD_STEP, 1'b0);
        drive_item(door_mon_pkg::CMD_TICK, 1'b0);
        drive_item(door_mon_pkg::CMD_STEP, 1'b0);
        settle();

        // short alarm, inverted pin, sampling on every step
        write_reg(door_mon_pkg::CFG_OPEN_LIMIT, 24'd2);
        write_reg(door_mon_pkg::CFG_INVERT, 24'd1);
        write_reg(door_mon_pkg::CFG_SAMPLE_INTERVAL, 24'd0);
        drive_item(door_mon_pkg::CMD_STEP, 1'b0);
        drive_item(door_mon_pkg::CMD_TICK, 1'b0);
        drive_item(door_mon_pkg::CMD_TICK, 1'b1);
        drive_item(door_mon_pkg::CMD_STEP, 1'b0);
        drive_item(door_mon_pkg::CMD_STEP, 1'b0);
        drive_item(door_mon_pkg::CMD_STEP, 1'b1);
        drive_item(door_mon_pkg::CMD_STEP, 1'b0);
        drive_item(door_mon_pkg::CMD_TICK, 1'b1);
        drive_item(door_mon_pkg::CMD_TICK, 1'b0);
        // alarm and close in the same step
        drive_item(door_mon_pkg::CMD_STEP, 1'b1);
        drive_item(door_mon_pkg::CMD_TICK, 1'b1);
        settle();

        // largest limit and interval, plus a write to an unmapped index
        write_reg(CFG_UNMAPPED, 24'hFFFFFF);
        write_reg(door_mon_pkg::CFG_OPEN_LIMIT, 24'hFFFFFF);
        write_reg(door_mon_pkg::CFG_INVERT, 24'hFFFFFE);
        write_reg(door_mon_pkg::CFG_SAMPLE_INTERVAL, 24'hFFFFFF);
        drive_item(door_mon_pkg::CMD_STEP, 1'b1);
        drive_item(door_mon_pkg::CMD_TICK, 1'b0);
        drive_item(door_mon_pkg::CMD_STEP, 1'b0);
        drive_item(door_mon_pkg::CMD_STEP, 1'b1);
        settle();

        while (sent < RANDOM_ITEMS)
        begin
            random_setting();
            gaps_on = (phase != 4);
            run_len = $urandom_range(90, 30);
            repeat (run_len)
            begin
                // door level changes now and then, so opens last a while
                if ($urandom_range(3) == 0)
                    pin_level = ~pin_level;
                drive_item(1'($urandom_range(1)), pin_level);
                sent++;
            end
            settle();
            phase++;
        end
        gaps_on = 1'b1;

        repeat (10) @(posedge clk);
        if (board.fails == 0 && board.owed.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/door_mon_pkg.sv
rtl/core/door_open_monitor_core.sv
rtl/core/door_mon_checker.sv
tb/door_open_monitor_core_tb.sv
